/* src/nnts_pkg.sv */
// Shared types and constants of the nearest-node tree store.
package nnts_pkg;

   localparam int ANGLE_W = 16;
   localparam int INDEX_W = 12;
   localparam int DIST_W  = 18;
   localparam int COST_W  = 32;

   localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
   localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

   typedef enum logic [1:0] {
      CMD_START  = 2'd0,
      CMD_INSERT = 2'd1,
      CMD_QUERY  = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_FULL       = 2'd1,
      STATUS_EMPTY      = 2'd2,
      STATUS_BAD_PARENT = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_ROOT,
      S_PBASE,
      S_SCAN,
      S_DRAIN,
      S_SQRT,
      S_FINISH
   } state_type;

   typedef struct packed {
      cmd_type                    cmd;
      logic signed [ANGLE_W-1:0]  angle_0;
      logic signed [ANGLE_W-1:0]  angle_1;
      logic signed [ANGLE_W-1:0]  angle_2;
      logic signed [ANGLE_W-1:0]  angle_3;
      logic signed [ANGLE_W-1:0]  angle_4;
      logic signed [ANGLE_W-1:0]  angle_5;
      logic signed [ANGLE_W-1:0]  angle_6;
      logic [INDEX_W-1:0]         parent_index;
   } req_type;

   typedef struct packed {
      logic [INDEX_W-1:0] out_index;
      logic [DIST_W-1:0]  out_distance;
      logic [COST_W-1:0]  out_cost;
      status_type         status;
   } rsp_type;

endpackage

/* src/nnts_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module nnts_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [0:DEPTH-1];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

/* src/nearest_node_tree_store.sv */
// Top level of the nearest-node tree store: sequencer, scan pipeline and square root.
//
// This block keeps a tree of up to NODES configurations of JOINTS joint angles and
// serves three commands, one beat at a time: start (clear the tree and store the
// root at index 0 with cost 0), insert (append a node below a stored parent, with
// the parent's cost plus the Euclidean distance to it, saturating at 32 bits) and
// query (return the lowest index at the smallest Euclidean distance, with that
// distance). A command beat is taken when start is high and busy is low; busy
// stays high until the result has been issued. Every command produces exactly one
// result beat, marked by rsp_valid for a single cycle, and the receiver must take
// it then, as there is no way to hold it off. Commands that fail their checks
// (empty tree, full tree, parent not stored) and unknown command codes answer in
// the cycle after acceptance and leave busy low. All distance work goes through
// one squaring multiplier that handles one joint per cycle, fed by the single read
// port of the angle memory, followed by a square root that settles one bit per
// cycle, RT_W bits in all (18 with the default parameters). Memory contents
// need no clearing after reset: only entries below the node count are ever read.
module nearest_node_tree_store #(
   parameter int NODES      = 4096,
   parameter int JOINTS     = 7,
   parameter int ANGLE_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  nnts_pkg::req_type req_data,
   output logic              rsp_valid,
   output nnts_pkg::rsp_type rsp_data
);

   import nnts_pkg::*;

   localparam int IDX_W     = $clog2(NODES);
   localparam int CNT_W     = $clog2(NODES + 1);
   localparam int ANG_DEPTH = NODES * JOINTS;
   localparam int ANG_AW    = $clog2(ANG_DEPTH);
   localparam int J_W       = (JOINTS > 1) ? $clog2(JOINTS) : 1;
   localparam int SUM_W     = 2 * ANGLE_BITS + $clog2(JOINTS);
   localparam int RT_W      = (SUM_W + 1) / 2;
   localparam int X_W       = 2 * RT_W;
   localparam int SC_W      = $clog2(RT_W + 1);
   localparam int CMP_W     = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;
   localparam int EXT_W     = (RT_W > DIST_W) ? RT_W : DIST_W;

   localparam logic [J_W-1:0] J_LAST = J_W'(JOINTS - 1);

   // Sequencer registers and their next values.
   state_type               state_ff, state_in;
   req_type                 req_ff, req_in;
   logic [J_W-1:0]          joint_ff, joint_in;
   logic [IDX_W-1:0]        node_ff, node_in;
   logic [IDX_W-1:0]        scan_end_ff, scan_end_in;
   logic [ANG_AW-1:0]       rd_addr_ff, rd_addr_in;
   logic [ANG_AW-1:0]       wr_addr_ff, wr_addr_in;
   logic [CNT_W-1:0]        node_count_ff, node_count_in;
   logic [ANG_AW-1:0]       ins_base_ff, ins_base_in;
   logic [SC_W-1:0]         sq_cnt_ff, sq_cnt_in;
   logic [X_W-1:0]          x_ff, x_in;
   logic [RT_W:0]           rem_ff, rem_in;
   logic [RT_W-1:0]         root_ff, root_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_ff, rsp_in;

   // Memory ports.
   logic                    ang_wr_en;
   logic [ANGLE_BITS-1:0]   ang_wr_data;
   logic [ANGLE_BITS-1:0]   ang_rd_data;
   logic                    cost_wr_en;
   logic [IDX_W-1:0]        cost_wr_addr;
   logic [COST_W-1:0]       cost_wr_data;
   logic [COST_W-1:0]       cost_rd_data;

   // Query angles of the current command, brought to the stored angle width.
   logic [ANGLE_W-1:0]          raw_angle [0:6];
   logic [ANGLE_BITS-1:0]       q_angle   [0:JOINTS-1];

   // Scan pipeline: read, absolute difference, square, accumulate, compare.
   logic                    issue;
   logic                    p1_valid_ff, p1_last_ff, p1_first_ff;
   logic [J_W-1:0]          p1_joint_ff;
   logic [IDX_W-1:0]        p1_node_ff;
   logic                    p2_valid_ff, p2_j0_ff, p2_last_ff, p2_first_ff;
   logic [IDX_W-1:0]        p2_node_ff;
   logic                    p3_valid_ff, p3_j0_ff, p3_last_ff, p3_first_ff;
   logic [IDX_W-1:0]        p3_node_ff;
   logic [ANGLE_BITS:0]     diff;
   logic [ANGLE_BITS-1:0]   a_ff;
   logic [2*ANGLE_BITS-1:0] sq_ff;
   logic [SUM_W-1:0]        acc_ff;
   logic [SUM_W-1:0]        acc_sum;
   logic                    sum_valid_ff, sum_first_ff;
   logic [SUM_W-1:0]        sum_ff;
   logic [IDX_W-1:0]        sum_node_ff;
   logic [SUM_W-1:0]        best_ff;
   logic [IDX_W-1:0]        best_idx_ff;
   logic                    pipe_busy;

   // One step of the bit-serial square root.
   logic [RT_W+2:0]         rem_t;
   logic [RT_W+2:0]         trial;
   logic                    root_bit;
   logic [RT_W:0]           rem_step;
   logic [RT_W-1:0]         root_step;

   // Result arithmetic.
   logic [COST_W:0]         cost_sum;
   logic [COST_W-1:0]       cost_sat;
   logic [EXT_W-1:0]        root_ext;
   logic [DIST_W-1:0]       dist_sat;
   logic                    accept;

   nnts_ram #(
      .WIDTH (ANGLE_BITS),
      .DEPTH (ANG_DEPTH)
   ) u_angle_ram (
      .clock   (clock),
      .wr_en   (ang_wr_en),
      .wr_addr (wr_addr_ff),
      .wr_data (ang_wr_data),
      .rd_addr (rd_addr_ff),
      .rd_data (ang_rd_data)
   );

   // The parent's cost is read continuously; its address holds for the whole insert.
   nnts_ram #(
      .WIDTH (COST_W),
      .DEPTH (NODES)
   ) u_cost_ram (
      .clock   (clock),
      .wr_en   (cost_wr_en),
      .wr_addr (cost_wr_addr),
      .wr_data (cost_wr_data),
      .rd_addr (IDX_W'(req_ff.parent_index)),
      .rd_data (cost_rd_data)
   );

   // A stored angle is the low ANGLE_BITS of the field, read as signed; a wider
   // store simply zero-extends the 16-bit field.
   always_comb begin
      raw_angle[0] = req_ff.angle_0;
      raw_angle[1] = req_ff.angle_1;
      raw_angle[2] = req_ff.angle_2;
      raw_angle[3] = req_ff.angle_3;
      raw_angle[4] = req_ff.angle_4;
      raw_angle[5] = req_ff.angle_5;
      raw_angle[6] = req_ff.angle_6;
      for (int j = 0; j < JOINTS; j++) begin
         q_angle[j] = ANGLE_BITS'(raw_angle[j]);
      end
   end

   assign ang_wr_data = q_angle[joint_ff];
   assign accept      = start && (state_ff == S_IDLE);
   assign busy        = (state_ff != S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_data    = rsp_ff;

   // Stage A: difference against the query angle of the same joint.
   assign diff = {ang_rd_data[ANGLE_BITS-1], ang_rd_data}
               - {q_angle[p1_joint_ff][ANGLE_BITS-1], q_angle[p1_joint_ff]};

   // Stage C: running sum over the joints of one node.
   assign acc_sum = (p3_j0_ff ? SUM_W'(0) : acc_ff) + SUM_W'(sq_ff);

   assign pipe_busy = p1_valid_ff || p2_valid_ff || p3_valid_ff || sum_valid_ff;

   // Restoring square root: bring down two bits, try to subtract 4 * root + 1.
   assign rem_t     = {rem_ff, x_ff[X_W-1 -: 2]};
   assign trial     = {1'b0, root_ff, 2'b01};
   assign root_bit  = (rem_t >= trial);
   assign rem_step  = root_bit ? (RT_W + 1)'(rem_t - trial) : rem_t[RT_W:0];
   assign root_step = {root_ff[RT_W-2:0], root_bit};

   // The path cost saturates at the top of 32 bits, the distance at 18 bits.
   assign cost_sum = {1'b0, cost_rd_data} + (COST_W + 1)'(root_ff);
   assign cost_sat = cost_sum[COST_W] ? COST_MAX : cost_sum[COST_W-1:0];
   assign root_ext = EXT_W'(root_ff);
   assign dist_sat = (root_ext > EXT_W'(DIST_MAX)) ? DIST_MAX : root_ext[DIST_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      joint_in      = joint_ff;
      node_in       = node_ff;
      scan_end_in   = scan_end_ff;
      rd_addr_in    = rd_addr_ff;
      wr_addr_in    = wr_addr_ff;
      node_count_in = node_count_ff;
      ins_base_in   = ins_base_ff;
      sq_cnt_in     = sq_cnt_ff;
      x_in          = x_ff;
      rem_in        = rem_ff;
      root_in       = root_ff;
      rsp_valid_in  = 1'b0;
      rsp_in        = rsp_ff;
      ang_wr_en     = 1'b0;
      cost_wr_en    = 1'b0;
      cost_wr_addr  = IDX_W'(node_count_ff);
      cost_wr_data  = cost_sat;
      issue         = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               req_in   = req_data;
               rsp_in   = '0;
               joint_in = '0;
               node_in  = '0;
               unique case (req_data.cmd)
                  CMD_START: begin
                     wr_addr_in = '0;
                     state_in   = S_ROOT;
                  end
                  CMD_INSERT: begin
                     if (node_count_ff == '0) begin
                        rsp_in.status = STATUS_EMPTY;
                        rsp_valid_in  = 1'b1;
                     end else if (node_count_ff >= CNT_W'(NODES)) begin
                        rsp_in.status = STATUS_FULL;
                        rsp_valid_in  = 1'b1;
                     end else if (CMP_W'(req_data.parent_index) >= CMP_W'(node_count_ff)) begin
                        rsp_in.status = STATUS_BAD_PARENT;
                        rsp_valid_in  = 1'b1;
                     end else begin
                        wr_addr_in  = ins_base_ff;
                        scan_end_in = '0;
                        state_in    = S_PBASE;
                     end
                  end
                  CMD_QUERY: begin
                     if (node_count_ff == '0) begin
                        rsp_in.status = STATUS_EMPTY;
                        rsp_valid_in  = 1'b1;
                     end else begin
                        rd_addr_in  = '0;
                        scan_end_in = IDX_W'(node_count_ff - 1'b1);
                        state_in    = S_SCAN;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end

         S_ROOT: begin
            ang_wr_en  = 1'b1;
            wr_addr_in = wr_addr_ff + 1'b1;
            joint_in   = J_W'(joint_ff + 1'b1);
            if (joint_ff == J_LAST) begin
               cost_wr_en    = 1'b1;
               cost_wr_addr  = '0;
               cost_wr_data  = '0;
               node_count_in = CNT_W'(1);
               ins_base_in   = ANG_AW'(JOINTS);
               rsp_in        = '0;
               rsp_valid_in  = 1'b1;
               state_in      = S_IDLE;
            end
         end

         S_PBASE: begin
            rd_addr_in = ANG_AW'(IDX_W'(req_ff.parent_index) * JOINTS);
            state_in   = S_SCAN;
         end

         S_SCAN: begin
            issue      = 1'b1;
            // An insert writes the new node's angles while the parent's are read.
            ang_wr_en  = (req_ff.cmd == CMD_INSERT);
            wr_addr_in = wr_addr_ff + 1'b1;
            rd_addr_in = rd_addr_ff + 1'b1;
            if (joint_ff == J_LAST) begin
               joint_in = '0;
               node_in  = node_ff + 1'b1;
               if (node_ff == scan_end_ff) begin
                  state_in = S_DRAIN;
               end
            end else begin
               joint_in = J_W'(joint_ff + 1'b1);
            end
         end

         S_DRAIN: begin
            if (!pipe_busy) begin
               x_in      = X_W'(best_ff);
               rem_in    = '0;
               root_in   = '0;
               sq_cnt_in = SC_W'(RT_W);
               state_in  = S_SQRT;
            end
         end

         S_SQRT: begin
            x_in      = {x_ff[X_W-3:0], 2'b00};
            rem_in    = rem_step;
            root_in   = root_step;
            sq_cnt_in = sq_cnt_ff - 1'b1;
            if (sq_cnt_ff == SC_W'(1)) begin
               state_in = S_FINISH;
            end
         end

         S_FINISH: begin
            rsp_in = '0;
            if (req_ff.cmd == CMD_INSERT) begin
               cost_wr_en       = 1'b1;
               rsp_in.out_index = INDEX_W'(node_count_ff);
               rsp_in.out_cost  = cost_sat;
               node_count_in    = node_count_ff + 1'b1;
               ins_base_in      = ANG_AW'(ins_base_ff + JOINTS);
            end else begin
               rsp_in.out_index    = INDEX_W'(best_idx_ff);
               rsp_in.out_distance = dist_sat;
            end
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= '0;
         ins_base_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         node_count_ff <= node_count_in;
         ins_base_ff   <= ins_base_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      req_ff      <= req_in;
      joint_ff    <= joint_in;
      node_ff     <= node_in;
      scan_end_ff <= scan_end_in;
      rd_addr_ff  <= rd_addr_in;
      wr_addr_ff  <= wr_addr_in;
      sq_cnt_ff   <= sq_cnt_in;
      x_ff        <= x_in;
      rem_ff      <= rem_in;
      root_ff     <= root_in;
      rsp_ff      <= rsp_in;
   end

   // Pipeline valid flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff  <= 1'b0;
         p2_valid_ff  <= 1'b0;
         p3_valid_ff  <= 1'b0;
         sum_valid_ff <= 1'b0;
      end else begin
         p1_valid_ff  <= issue;
         p2_valid_ff  <= p1_valid_ff;
         p3_valid_ff  <= p2_valid_ff;
         sum_valid_ff <= p3_valid_ff && p3_last_ff;
      end
   end

   // Pipeline data and tags.
   always_ff @(posedge clock) begin
      p1_joint_ff <= joint_ff;
      p1_last_ff  <= (joint_ff == J_LAST);
      p1_node_ff  <= node_ff;
      p1_first_ff <= (node_ff == '0);

      a_ff        <= diff[ANGLE_BITS] ? ANGLE_BITS'(~diff + 1'b1) : diff[ANGLE_BITS-1:0];
      p2_j0_ff    <= (p1_joint_ff == '0);
      p2_last_ff  <= p1_last_ff;
      p2_node_ff  <= p1_node_ff;
      p2_first_ff <= p1_first_ff;

      sq_ff       <= a_ff * a_ff;
      p3_j0_ff    <= p2_j0_ff;
      p3_last_ff  <= p2_last_ff;
      p3_node_ff  <= p2_node_ff;
      p3_first_ff <= p2_first_ff;

      if (p3_valid_ff) begin
         acc_ff <= acc_sum;
      end
      sum_ff       <= acc_sum;
      sum_node_ff  <= p3_node_ff;
      sum_first_ff <= p3_first_ff;

      // A strict compare keeps the lowest index among equal distances.
      if (sum_valid_ff && (sum_first_ff || (sum_ff < best_ff))) begin
         best_ff     <= sum_ff;
         best_idx_ff <= sum_node_ff;
      end
   end

`ifndef ASSERT_OFF
   a_count_bounded : assert property (@(posedge clock) disable iff (reset)
      node_count_ff <= CNT_W'(NODES))
      else $error("node count beyond the store depth");

   a_sqrt_after_drain : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SQRT) |-> !pipe_busy)
      else $error("square root started with distance work still in flight");

   a_insert_grows : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FINISH && req_ff.cmd == CMD_INSERT)
      |=> node_count_ff == CNT_W'($past(node_count_ff) + 1'b1))
      else $error("good insert did not add exactly one node");

   a_result_when_idle : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == S_IDLE))
      else $error("result beat issued while a command is still running");

   a_query_busy : assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.cmd == CMD_QUERY && node_count_ff != '0) |=> busy)
      else $error("query on a stored tree did not start a scan");
`endif

endmodule

/* test/testbench.sv */
// Self-checking testbench for the nearest-node tree store: directed and random command beats.
`timescale 1ns / 100ps

module testbench;

   import nnts_pkg::*;

   localparam int NODES        = 4096;
   localparam int JOINTS       = 7;
   localparam int RANDOM_ITEMS = 115;
   localparam int END_PAUSE    = 64;
   localparam int REPORT_MAX   = 10;

   // No tree grows beyond about 160 nodes, so CYCLE_LIMIT stands far above what the
   // whole run of command beats needs.
   localparam int CYCLE_LIMIT = 2000000;

   // The one command code that the package does not name: the block answers it with an
   // all-zero result and leaves the tree untouched.
   localparam logic [1:0] CMD_UNKNOWN = 2'd3;

   typedef struct {
      req_type     req;
      int unsigned gap;
      bit          drain;
   } cmd_slot_type;

   logic    clock = 1'b0;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;

   always #1 clock = ~clock;

   nearest_node_tree_store #(
      .NODES(NODES),
      .JOINTS(JOINTS),
      .ANGLE_BITS(ANGLE_W)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_data(rsp_data)
   );

   // Command beats waiting to be driven, and the answers that accepted beats still owe.
   cmd_slot_type cmd_backlog[$];
   rsp_type      due_answers[$];

   // Our own picture of the tree, updated as each command beat is accepted.
   req_type          tree_nodes [NODES];
   logic [COST_W-1:0] tree_costs [NODES];
   int unsigned      tree_size;

   // The stimulus builder keeps a separate view of the tree so that it can aim inserts at
   // stored parents and queries at stored poses before anything has run.
   req_type plan_tree[$];
   int unsigned burst_left;

   int unsigned error_count;
   int unsigned cycle_count;
   bit          beat_taken;
   int unsigned gap_left;
   logic        go;

   function automatic logic signed [ANGLE_W-1:0] pose_angle(req_type r, int j);
      case (j)
         0: return r.angle_0;
         1: return r.angle_1;
         2: return r.angle_2;
         3: return r.angle_3;
         4: return r.angle_4;
         5: return r.angle_5;
         default: return r.angle_6;
      endcase
   endfunction

   // Exact squared Euclidean distance between two poses, an unsigned integer in squared angle units.
   function automatic longint unsigned span_sq(req_type a, req_type b);
      longint unsigned acc;
      longint diff;
      int j;
      acc = 0;
      for (j = 0; j < JOINTS; j++) begin
         diff = longint'(pose_angle(a, j)) - longint'(pose_angle(b, j));
         acc = acc + diff * diff;
      end
      return acc;
   endfunction

   // Floor of the square root, settled two bits of the radicand at a time.
   function automatic longint unsigned floor_root(longint unsigned x);
      longint unsigned res;
      longint unsigned probe;
      res = 0;
      probe = 64'd1 << 62;
      while (probe > x) probe = probe >> 2;
      while (probe != 0) begin
         if (x >= res + probe) begin
            x = x - (res + probe);
            res = (res >> 1) + probe;
         end else begin
            res = res >> 1;
         end
         probe = probe >> 2;
      end
      return res;
   endfunction

   // Applies one accepted command to our tree and queues the answer it must produce.
   task automatic predict_answer(req_type r);
      rsp_type         ans;
      longint unsigned cost;
      longint unsigned best_sq;
      longint unsigned sq;
      longint unsigned root_dist;
      int unsigned     best;
      int unsigned     i;
      ans = '0;
      case (r.cmd)
         CMD_START: begin
            tree_nodes[0] = r;
            tree_costs[0] = '0;
            tree_size = 1;
         end
         CMD_INSERT: begin
            if (tree_size == 0) begin
               ans.status = STATUS_EMPTY;
            end else if (tree_size >= NODES) begin
               ans.status = STATUS_FULL;
            end else if (r.parent_index >= tree_size) begin
               ans.status = STATUS_BAD_PARENT;
            end else begin
               cost = longint'(tree_costs[r.parent_index])
                      + floor_root(span_sq(tree_nodes[r.parent_index], r));
               if (cost > COST_MAX) cost = COST_MAX;
               tree_nodes[tree_size] = r;
               tree_costs[tree_size] = cost[COST_W-1:0];
               ans.out_index = tree_size[INDEX_W-1:0];
               ans.out_cost = cost[COST_W-1:0];
               tree_size++;
            end
         end
         CMD_QUERY: begin
            if (tree_size == 0) begin
               ans.status = STATUS_EMPTY;
            end else begin
               // Strictly smaller only, so the lowest index wins a tie.
               best = 0;
               best_sq = span_sq(tree_nodes[0], r);
               for (i = 1; i < tree_size; i++) begin
                  sq = span_sq(tree_nodes[i], r);
                  if (sq < best_sq) begin
                     best_sq = sq;
                     best = i;
                  end
               end
               root_dist = floor_root(best_sq);
               if (root_dist > DIST_MAX) root_dist = DIST_MAX;
               ans.out_index = best[INDEX_W-1:0];
               ans.out_distance = root_dist[DIST_W-1:0];
            end
         end
         default: begin
         end
      endcase
      due_answers.push_back(ans);
   endtask

   task automatic note_mismatch(string what, rsp_type want, rsp_type got);
      error_count++;
      if (error_count <= REPORT_MAX) begin
         $display("[%0t] %s: expected index %0d distance %0d cost %0d status %0d,",
                  $realtime, what, want.out_index, want.out_distance, want.out_cost,
                  want.status);
         $display("   got index %0d distance %0d cost %0d status %0d",
                  got.out_index, got.out_distance, got.out_cost, got.status);
      end
   endtask

   // Mostly small angles so that neighbours sit close together, with full-range values and
   // both ends of the range mixed in.
   function automatic logic [ANGLE_W-1:0] rand_angle();
      int unsigned pick;
      pick = $urandom_range(0, 9);
      if (pick < 6) return ANGLE_W'(int'($urandom_range(0, 1023)) - 512);
      if (pick < 8) return ANGLE_W'($urandom);
      if (pick == 8) return 16'h8000;
      return 16'h7FFF;
   endfunction

   function automatic req_type make_pose(cmd_type cmd, int unsigned parent);
      req_type r;
      r = '0;
      r.cmd = cmd;
      r.angle_0 = rand_angle();
      r.angle_1 = rand_angle();
      r.angle_2 = rand_angle();
      r.angle_3 = rand_angle();
      r.angle_4 = rand_angle();
      r.angle_5 = rand_angle();
      r.angle_6 = rand_angle();
      r.parent_index = parent[INDEX_W-1:0];
      return r;
   endfunction

   function automatic req_type uniform_pose(cmd_type cmd, logic [ANGLE_W-1:0] a,
                                           int unsigned parent);
      req_type r;
      r = '0;
      r.cmd = cmd;
      r.angle_0 = a;
      r.angle_1 = a;
      r.angle_2 = a;
      r.angle_3 = a;
      r.angle_4 = a;
      r.angle_5 = a;
      r.angle_6 = a;
      r.parent_index = parent[INDEX_W-1:0];
      return r;
   endfunction

   // Idle cycles ahead of a beat: mostly none or a few, now and then a long pause, with
   // occasional stretches of back-to-back beats.
   function automatic int unsigned rand_gap();
      int unsigned pick;
      if (burst_left != 0) begin
         burst_left--;
         return 0;
      end
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
         burst_left = $urandom_range(10, 30);
         return 0;
      end
      if (pick < 60) return 0;
      if (pick < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Queues a beat and keeps the builder's view of the tree in step with it.
   task automatic plan_cmd(req_type r, bit drain);
      cmd_slot_type slot;
      slot.req = r;
      slot.gap = rand_gap();
      slot.drain = drain;
      cmd_backlog.push_back(slot);
      if (r.cmd == CMD_START) begin
         plan_tree.delete();
         plan_tree.push_back(r);
      end else if (r.cmd == CMD_INSERT && plan_tree.size() != 0
                   && plan_tree.size() < NODES && r.parent_index < plan_tree.size()) begin
         plan_tree.push_back(r);
      end
   endtask

   // Driver: presents beats at the falling edge and holds each one until it is taken.
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         go = start;
         if (start && beat_taken) begin
            go = 1'b0;
            gap_left = (cmd_backlog.size() != 0) ? cmd_backlog[0].gap : 0;
         end
         if (!go && cmd_backlog.size() != 0) begin
            if (gap_left != 0) begin
               gap_left--;
            end else if (!cmd_backlog[0].drain || due_answers.size() == 0) begin
               req_data <= cmd_backlog[0].req;
               go = 1'b1;
               void'(cmd_backlog.pop_front());
            end
         end
         start <= go;
      end
   end

   // Monitor: checks any answer leaving the block, then records a beat accepted at this
   // edge. An answer is never due at the edge that accepts its own command, so checking
   // first keeps the order of expectations right.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else if (!reset) begin
         if (rsp_valid) begin
            if (due_answers.size() == 0) begin
               note_mismatch("answer with nothing due", '0, rsp_data);
            end else if (rsp_data.out_index !== due_answers[0].out_index
                         || rsp_data.out_distance !== due_answers[0].out_distance
                         || rsp_data.out_cost !== due_answers[0].out_cost
                         || rsp_data.status !== due_answers[0].status) begin
               note_mismatch("answer mismatch", due_answers[0], rsp_data);
               void'(due_answers.pop_front());
            end else begin
               void'(due_answers.pop_front());
            end
         end
         beat_taken = start && !busy;
         if (beat_taken) predict_answer(req_data);
      end else begin
         beat_taken = 1'b0;
      end
   end

   initial begin : stimulus
      req_type     r;
      int unsigned counted;
      int unsigned pick;
      int unsigned size;
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      tree_size = 0;
      error_count = 0;
      cycle_count = 0;
      gap_left = 0;
      burst_left = 0;
      beat_taken = 1'b0;

      // Directed part: empty tree first, then the range extremes, bad parents, ties,
      // the unknown code and a restart of a tree that is already populated.
      plan_cmd(uniform_pose(CMD_QUERY, 16'h0000, 0), 1'b0);
      plan_cmd(uniform_pose(CMD_INSERT, 16'h0000, 0), 1'b0);
      r = make_pose(CMD_START, 0);
      r.cmd = cmd_type'(CMD_UNKNOWN);
      plan_cmd(r, 1'b0);
      plan_cmd(uniform_pose(CMD_START, 16'h8000, 12'hFFF), 1'b0);
      plan_cmd(uniform_pose(CMD_INSERT, 16'h7FFF, 0), 1'b0);
      plan_cmd(uniform_pose(CMD_INSERT, 16'h0000, 2), 1'b0);
      plan_cmd(uniform_pose(CMD_INSERT, 16'h0000, 4095), 1'b0);
      plan_cmd(uniform_pose(CMD_INSERT, 16'h0000, 1), 1'b0);
      plan_cmd(uniform_pose(CMD_QUERY, 16'h0000, 0), 1'b0);
      // A copy of the root, so that a query at the root's pose sees a tie.
      plan_cmd(uniform_pose(CMD_INSERT, 16'h8000, 0), 1'b0);
      plan_cmd(uniform_pose(CMD_QUERY, 16'h8000, 3), 1'b0);
      plan_cmd(uniform_pose(CMD_QUERY, 16'h7FFF, 0), 1'b0);
      plan_cmd(uniform_pose(CMD_INSERT, 16'h7FFF, 3), 1'b0);
      r = uniform_pose(CMD_QUERY, 16'h0000, 0);
      r.cmd = cmd_type'(CMD_UNKNOWN);
      plan_cmd(r, 1'b0);
      r = uniform_pose(CMD_START, 16'h5555, 0);
      r.angle_1 = 16'hAAAA;
      r.angle_3 = 16'hAAAA;
      r.angle_5 = 16'hAAAA;
      plan_cmd(r, 1'b0);
      plan_cmd(uniform_pose(CMD_QUERY, 16'h8000, 0), 1'b0);
      plan_cmd(uniform_pose(CMD_INSERT, 16'h1234, 1), 1'b0);
      plan_cmd(make_pose(CMD_INSERT, 0), 1'b0);
      plan_cmd(make_pose(CMD_QUERY, 0), 1'b0);

      // Random part: mostly inserts under stored parents and queries, some of them at
      // stored poses, with occasional restarts, bad parents and unknown codes. Halfway
      // through the sender waits for every outstanding answer.
      counted = 0;
      while (counted < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         size = plan_tree.size();
         if (size == 0 || pick < 4) begin
            r = make_pose(CMD_START, $urandom_range(0, 4095));
         end else if (pick < 52) begin
            if ($urandom_range(0, 4) == 0) r = plan_tree[$urandom_range(0, size - 1)];
            else r = make_pose(CMD_INSERT, 0);
            r.cmd = CMD_INSERT;
            r.parent_index = INDEX_W'($urandom_range(0, size - 1));
         end else if (pick < 58) begin
            r = make_pose(CMD_INSERT, $urandom_range(size, 4095));
         end else if (pick < 94) begin
            if ($urandom_range(0, 2) == 0) r = plan_tree[$urandom_range(0, size - 1)];
            else r = make_pose(CMD_QUERY, 0);
            r.cmd = CMD_QUERY;
            r.parent_index = INDEX_W'($urandom_range(0, 4095));
         end else begin
            r = make_pose(CMD_START, $urandom_range(0, 4095));
            r.cmd = cmd_type'(CMD_UNKNOWN);
         end
         plan_cmd(r, counted == RANDOM_ITEMS / 2);
         if (r.cmd != cmd_type'(CMD_UNKNOWN)) counted++;
      end

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (cmd_backlog.size() != 0 || start) @(posedge clock);
      while (due_answers.size() != 0) @(posedge clock);
      repeat (END_PAUSE) @(posedge clock);

      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
